@@ src/lbp3_pkg.sv @@
// Shared types and constants of the 3x3 local binary pattern unit.
`default_nettype none

package lbp3_pkg;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 10;
  localparam int WIDTH_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W   = 13;
  localparam int LINE_W  = 2 * PIX_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;
  localparam int WIDTH_CAP = 1024;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // One pixel request on its way from the counter stage to the window stage.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } item_t;

endpackage

`default_nettype wire

@@ src/lbp3_line_mem.sv @@
// Line memory: upper and middle row bytes per column, one read and one write port.
`default_nettype none

module lbp3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [AW-1:0]                rd_addr_i,
  output logic      [lbp3_pkg::LINE_W-1:0]  rd_data_o,
  input  wire logic                         wr_en_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic [lbp3_pkg::LINE_W-1:0]  wr_data_i
);

  logic [lbp3_pkg::LINE_W-1:0] mem_q [DEPTH];
  logic [lbp3_pkg::LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold the read data until the next read so a stalled request keeps its rows.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/lbp3_window.sv @@
// 3x3 window registers, pattern compare and output register.
`default_nettype none

module lbp3_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire lbp3_pkg::item_t               item_i,
  input  wire logic [lbp3_pkg::PIX_W-1:0]    up_i,
  input  wire logic [lbp3_pkg::PIX_W-1:0]    mid_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [lbp3_pkg::PIX_W-1:0]    pattern_code_o,
  output logic      [lbp3_pkg::ROW_W-1:0]    center_row_o,
  output logic      [lbp3_pkg::COL_W-1:0]    center_col_o,
  output logic                               frame_last_o
);

  logic [lbp3_pkg::PIX_W-1:0] win_q [9];
  logic [lbp3_pkg::PIX_W-1:0] win_d [9];
  logic [lbp3_pkg::PIX_W-1:0] code;
  logic                       out_valid_q, out_valid_d;
  logic [lbp3_pkg::PIX_W-1:0] code_q;
  logic [lbp3_pkg::ROW_W-1:0] row_q;
  logic [lbp3_pkg::COL_W-1:0] col_q;
  logic                       last_q;

  assign out_free_o = !out_valid_q || out_ready_i;

  // Shift left by one column; the new column enters on the right.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3 + 0] = win_q[k*3 + 0];
      win_d[k*3 + 1] = win_q[k*3 + 1];
      win_d[k*3 + 2] = win_q[k*3 + 2];
    end
    if (fire_i) begin
      for (int k = 0; k < 3; k++) begin
        win_d[k*3 + 0] = win_q[k*3 + 1];
        win_d[k*3 + 1] = win_q[k*3 + 2];
      end
      win_d[2] = up_i;
      win_d[5] = mid_i;
      win_d[8] = item_i.pixel;
    end
  end

  // Neighbors in row-major order, skipping the center.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      code[k] = (win_d[(k < 4) ? k : k + 1] >= win_d[4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire_i && item_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && item_i.emit) begin
      code_q <= code;
      row_q  <= item_i.row;
      col_q  <= item_i.col;
      last_q <= item_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pattern_code_o = code_q;
  assign center_row_o   = row_q;
  assign center_col_o   = col_q;
  assign frame_last_o   = last_q;

endmodule

`default_nettype wire

@@ src/local_binary_pattern_3x3_unit.sv @@
// Top level of the streaming 3x3 local binary pattern unit.
`default_nettype none

// Streaming 3x3 local binary pattern unit. Send 8-bit grayscale pixels in
// raster order on the pixel channel; for every interior pixel one request
// leaves on the result channel with its 8-bit code (bit k set when the k-th
// neighbor, row-major with the center skipped, is greater than or equal to
// the center), the center row and column, and frame_last on the final code
// of a frame. Pixels in rows 0..1 or columns 0..1 produce nothing; each code
// refers to the pixel one row and one column behind the newest one. The unit
// takes one pixel per clock while the result side is not stalled; a held
// result stops the pixel channel once the stage in front of the output
// register is occupied. The edge that accepts a pixel performs the synchronous
// line memory read and fills the stage in front of the output register; the
// edge on which that stage moves on updates the window and loads the compare
// result into the output register. The line memory holds MAX_WIDTH
// entries of two bytes (upper and middle row); its contents are undefined
// after reset and are filled by the first two rows of a frame, so no
// clearing pass is needed. Write image_width (index 0) and image_height
// (index 1) only while the unit is idle; values outside
// 3..min(MAX_WIDTH,1024) and 3..4096 are clamped, width after keeping bits 10:0.
module local_binary_pattern_3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [lbp3_pkg::CFG_W-1:0]   cfg_data_i,
  // pixel channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lbp3_pkg::PIX_W-1:0]   pixel_value_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [lbp3_pkg::PIX_W-1:0]   pattern_code_o,
  output logic      [lbp3_pkg::ROW_W-1:0]   center_row_o,
  output logic      [lbp3_pkg::COL_W-1:0]   center_col_o,
  output logic                              frame_last_o
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WMAX = (MAX_WIDTH < lbp3_pkg::WIDTH_CAP) ? MAX_WIDTH : lbp3_pkg::WIDTH_CAP;
  localparam logic [lbp3_pkg::WIDTH_W-1:0] WIDTH_MAX = lbp3_pkg::WIDTH_W'(WMAX);

  // Configuration registers
  logic [lbp3_pkg::WIDTH_W-1:0]  width_q;
  logic [lbp3_pkg::HEIGHT_W-1:0] height_q;
  logic [lbp3_pkg::WIDTH_W-1:0]  eff_w;
  logic [lbp3_pkg::HEIGHT_W-1:0] eff_h;

  // Position counters
  logic [lbp3_pkg::ROW_W-1:0] row_q, row_d;
  logic [lbp3_pkg::COL_W-1:0] col_q, col_d;
  logic [lbp3_pkg::WIDTH_W-1:0]  col_inc;
  logic [lbp3_pkg::HEIGHT_W-1:0] row_inc;

  // Stage between memory read and window update
  logic            accept;
  logic            s1_valid_q, s1_valid_d;
  logic            s1_fire;
  lbp3_pkg::item_t item;
  lbp3_pkg::item_t s1_item_q;
  logic [AW-1:0]   s1_addr_q;
  logic [AW-1:0]   rd_addr;
  logic            out_free;

  logic [lbp3_pkg::LINE_W-1:0] rd_data;
  logic [lbp3_pkg::PIX_W-1:0]  up_px;
  logic [lbp3_pkg::PIX_W-1:0]  mid_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lbp3_pkg::WIDTH_RESET;
      height_q <= lbp3_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (lbp3_pkg::cfg_idx_e'(cfg_index_i))
        lbp3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[lbp3_pkg::WIDTH_W-1:0];
        lbp3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[lbp3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the counters and the line memory support.
  always_comb begin
    priority if (width_q < lbp3_pkg::WIDTH_MIN) begin
      eff_w = lbp3_pkg::WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = width_q;
    end
    priority if (height_q < lbp3_pkg::HEIGHT_MIN) begin
      eff_h = lbp3_pkg::HEIGHT_MIN;
    end else if (height_q > lbp3_pkg::HEIGHT_MAX) begin
      eff_h = lbp3_pkg::HEIGHT_MAX;
    end else begin
      eff_h = height_q;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && out_free;
  // Take a new pixel when the stage is empty or the held one moves on this cycle.
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign col_inc = {1'b0, col_q} + lbp3_pkg::WIDTH_W'(1);
  assign row_inc = {1'b0, row_q} + lbp3_pkg::HEIGHT_W'(1);

  // Tag the pixel: interior positions emit, the frame's final position marks last.
  always_comb begin
    item.emit  = (row_q >= lbp3_pkg::ROW_W'(2)) && (col_q >= lbp3_pkg::COL_W'(2)) &&
                 ({1'b0, row_q} < eff_h) && ({1'b0, col_q} < eff_w);
    item.last  = (row_inc == eff_h) && (col_inc == eff_w);
    item.row   = row_q - lbp3_pkg::ROW_W'(1);
    item.col   = col_q - lbp3_pkg::COL_W'(1);
    item.pixel = pixel_value_i;
  end

  // Advance column, wrap into the next row, wrap rows at frame end.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (col_inc >= eff_w) begin
        col_d = '0;
        if (row_inc >= eff_h) begin
          row_d = '0;
        end else begin
          row_d = row_inc[lbp3_pkg::ROW_W-1:0];
        end
      end else begin
        col_d = col_inc[lbp3_pkg::COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  assign rd_addr = AW'(col_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item;
      s1_addr_q <= rd_addr;
    end
  end

  // Read the column on accept, write it back (middle moves up, pixel becomes
  // middle) when the request enters the window. Successive pixels always sit
  // in different columns, so the read and the write never hit the same entry.
  assign up_px  = rd_data[lbp3_pkg::LINE_W-1:lbp3_pkg::PIX_W];
  assign mid_px = rd_data[lbp3_pkg::PIX_W-1:0];

  lbp3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid_px, s1_item_q.pixel})
  );

  lbp3_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_fire),
    .item_i         (s1_item_q),
    .up_i           (up_px),
    .mid_i          (mid_px),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pattern_code_o (pattern_code_o),
    .center_row_o   (center_row_o),
    .center_col_o   (center_col_o),
    .frame_last_o   (frame_last_o)
  );

`ifndef NO_ASSERTIONS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_fire) |-> (rd_addr != s1_addr_q))
    else $error("line memory read and write hit the same column");

  a_emit_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.emit) |=> out_valid_o)
    else $error("interior pixel did not produce a result");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("pixel channel stalled without a blocked result");

  a_col_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && (col_inc < eff_w)) |=> (col_q == $past(col_inc[lbp3_pkg::COL_W-1:0])))
    else $error("column counter did not advance");
`endif

endmodule

`default_nettype wire
